/* hw/rtl/swtl_pkg.sv */
// Shared types and fixed field widths of the sliding-window throughput limiter.
`default_nettype none
package swtl_pkg;

	localparam int TIME_W = 32;
	localparam int LEN_W  = 16;
	localparam int RATE_W = 32;

	// Length of the bucket window in seconds; a power of two, so the average is a shift.
	localparam int WINDOW_SECONDS = 8;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/swtl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module swtl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* hw/rtl/swtl_div.sv */
// Divider by a fixed power-of-two divisor, quotient registered on start.
`default_nettype none
module swtl_div
	import swtl_pkg::*;
#(
	parameter int DW      = 35,
	parameter int DIVISOR = 8,
	localparam int SHIFT = $clog2(DIVISOR)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	output div_ctl_t           ctl,
	output logic      [DW-1:0] quotient
);

	logic [DW-1:0] quot_q;

	// shift the dividend down by the divisor's exponent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
		end else if (start) begin
			quot_q <= dividend >> SHIFT;
		end
	end

	// busy only while the quotient register loads
	assign ctl.start = start;
	assign ctl.busy  = start;
	assign quotient  = quot_q;

endmodule
`default_nettype wire

/* hw/rtl/sliding_window_throughput_limiter.sv */
// Top level of the sliding-window throughput limiter: control, bucket RAM and divider.
//
//  channel | dir | handshake          | contents (lowest bit first)
//  --------+-----+--------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | now_seconds[31:0], data_length, extra_length
//  m_*     | out | m_tvalid/m_tready  | granted, average_rate[31:0], zero pad
//  cfg_*   | in  | cfg_we             | max_rate[31:0]
//
//  After reset the bucket RAM is swept to zero with s_tready low.
//  A packet runs a bucket sweep, zeroing the buckets that dropped off through the RAM
//  write port and reading the rest through the single read port, then a divide state
//  and a finish state; the average is a shift by the window length.
//  A packet with max_rate zero skips the sweep and divide and touches no state.
//  One packet is in flight at a time; a finished result waits in the output
//  register while the next transaction is taken, and a stalled m side holds the
//  last stage only.
`default_nettype none
module sliding_window_throughput_limiter
	import swtl_pkg::*;
#(
	parameter int HEADER_BYTES   = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // now_seconds[31:0], data_length[47:32], extra_length[63:48]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // granted[0], average_rate[32:1], zero[39:33]
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	localparam int AW    = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
	localparam int CW    = $clog2(WINDOW_SECONDS + 1);
	localparam int SUM_W = RATE_W + $clog2(WINDOW_SECONDS);
	localparam int PKT_W = LEN_W + 2;

	state_t state_q, state_d;

	logic [RATE_W-1:0] max_rate_q;
	logic [TIME_W-1:0] base_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     addr_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     zero_cnt_q;
	logic              bypass_q;
	logic [PKT_W-1:0]  pkt_len_q;
	logic [RATE_W-1:0] b0_q;
	logic [SUM_W-1:0]  acc_q;
	logic [RATE_W-1:0] avg_q;
	logic              rd_pend_s1;
	logic              first_s1;
	logic              out_granted_q;
	logic [RATE_W-1:0] out_avg_q;
	logic              m_valid_q;

	logic              s_acc;
	logic              out_free;
	logic [TIME_W-1:0] in_now;
	logic [TIME_W-1:0] diff;
	logic              ahead;
	logic              far;
	logic [CW-1:0]     shift_k;
	logic [AW+1:0]     head_tmp;
	logic [AW-1:0]     head_new;
	logic [AW-1:0]     addr_inc;
	logic [SUM_W-1:0]  acc_next;
	logic              grant;
	logic [RATE_W:0]   b0_add;
	logic [RATE_W-1:0] b0_sat;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [RATE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [RATE_W-1:0] ram_rdata;

	div_ctl_t          div_ctl;
	logic              div_start;
	logic [SUM_W-1:0]  div_quot;

	swtl_ram #(.WIDTH(RATE_W), .DEPTH(WINDOW_SECONDS)) u_buckets (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	swtl_div #(.DW(SUM_W), .DIVISOR(WINDOW_SECONDS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_next),
		.ctl      (div_ctl),
		.quotient (div_quot)
	);

	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign in_now   = s_tdata[TIME_W-1:0];

	// Window advance: how far time moved, and where bucket 0 lands in the ring
	always_comb begin
		ahead    = (in_now > base_q);
		diff     = in_now - base_q;
		far      = (diff > TIME_W'(WINDOW_SECONDS));
		if (!ahead) begin
			shift_k = '0;
		end else if (far) begin
			shift_k = CW'(WINDOW_SECONDS);
		end else begin
			shift_k = diff[CW-1:0];
		end
		// step the head back by shift_k places, modulo the window
		head_tmp = {2'b00, head_q} + (AW+2)'(WINDOW_SECONDS) - (AW+2)'(shift_k);
		if (head_tmp >= (AW+2)'(WINDOW_SECONDS)) begin
			head_tmp = head_tmp - (AW+2)'(WINDOW_SECONDS);
		end
		head_new = head_tmp[AW-1:0];
	end

	assign addr_inc = (addr_q == AW'(WINDOW_SECONDS - 1)) ? '0 : addr_q + 1'b1;
	assign acc_next = rd_pend_s1 ? acc_q + SUM_W'(ram_rdata) : acc_q;

	// Grant test and the saturating add into the newest bucket
	always_comb begin
		grant  = (avg_q <= max_rate_q);
		b0_add = {1'b0, b0_q} + (RATE_W+1)'(pkt_len_q);
		b0_sat = b0_add[RATE_W] ? '1 : b0_add[RATE_W-1:0];
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				// zero the ring one entry a cycle
				ram_we = 1'b1;
				if (cnt_q == CW'(WINDOW_SECONDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_acc) begin
					state_d = (max_rate_q == '0) ? ST_FINISH : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (cnt_q == CW'(WINDOW_SECONDS)) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else if (cnt_q < zero_cnt_q) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_DIV: begin
				if (!div_ctl.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
					if (!bypass_q && grant) begin
						ram_we    = 1'b1;
						ram_waddr = head_q;
						ram_wdata = b0_sat;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			max_rate_q <= '0;
			base_q     <= '0;
			head_q     <= '0;
			addr_q     <= '0;
			cnt_q      <= '0;
			zero_cnt_q <= '0;
			bypass_q   <= 1'b0;
			rd_pend_s1 <= 1'b0;
			first_s1   <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= ram_re;
			first_s1   <= ram_re && (cnt_q == '0);
			if (cfg_we) begin
				max_rate_q <= cfg_wdata;
			end
			// raise valid as the result is loaded, drop it once taken
			if (state_q == ST_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					addr_q <= addr_inc;
					cnt_q  <= cnt_q + 1'b1;
				end
				ST_IDLE: begin
					if (s_acc) begin
						bypass_q <= (max_rate_q == '0);
						cnt_q    <= '0;
						if (max_rate_q != '0) begin
							// advance the window now; the sweep zeroes what dropped off
							zero_cnt_q <= shift_k;
							head_q     <= head_new;
							addr_q     <= head_new;
							if (ahead) begin
								base_q <= in_now;
							end
						end
					end
				end
				ST_SWEEP: begin
					if (cnt_q != CW'(WINDOW_SECONDS)) begin
						addr_q <= addr_inc;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pkt_len_q <= PKT_W'(s_tdata[47:32]) + PKT_W'(s_tdata[63:48])
				+ PKT_W'(HEADER_BYTES);
			b0_q      <= '0;
			acc_q     <= '0;
		end else begin
			acc_q <= acc_next;
			if (first_s1) begin
				b0_q <= ram_rdata;
			end
		end
		if (state_q == ST_DIV && !div_ctl.busy) begin
			avg_q <= div_quot[RATE_W-1:0];
		end
		if (state_q == ST_FINISH && out_free) begin
			out_granted_q <= bypass_q || grant;
			out_avg_q     <= bypass_q ? '0 : avg_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, out_avg_q, out_granted_q};

endmodule
`default_nettype wire

/* test/sliding_window_throughput_limiter_tb.sv */
// Self-checking testbench for the sliding-window throughput limiter.
`default_nettype none
module sliding_window_throughput_limiter_tb
	import swtl_pkg::*;
();

	localparam int WIN      = WINDOW_SECONDS;
	localparam int HDR      = 12;
	localparam int LIMIT    = 8_000_000;
	localparam int N_PROBES = 21;
	localparam int N_PHASES = 12;
	localparam int PHASE_PKTS = 150;
	// Maximum-size packets piled into one second at the widest limit.
	localparam int PILE_PKTS = 60;
	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	typedef enum int {
		RX_STEADY,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_pattern_t;

	typedef struct packed {
		logic              granted;
		logic [RATE_W-1:0] avg;
	} decision_t;

	// One directed packet; a rate write precedes it when set_rate is high.
	typedef struct packed {
		bit                set_rate;
		logic [RATE_W-1:0] rate;
		logic [TIME_W-1:0] now;
		logic [LEN_W-1:0]  dlen;
		logic [LEN_W-1:0]  xlen;
		bit                known;
		bit                granted;
		logic [RATE_W-1:0] avg;
	} probe_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;   // now_seconds[31:0], data_length[47:32], extra_length[63:48]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;          // granted[0], average_rate[32:1], zero[39:33]
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// Shadow of the block's state, kept by the predictor.
	logic [RATE_W-1:0] bucket_mem [WIN];
	logic [TIME_W-1:0] win_base;
	logic [RATE_W-1:0] lim_rate;

	decision_t decision_q [$];
	int        mismatches   = 0;
	int        decisions_seen = 0;
	int        deferrals_seen = 0;
	int        packets_sent = 0;
	int        rate_writes  = 0;
	int        cycle_cnt    = 0;

	// Handshake between the stimulus and the receiver process.
	bit          rx_hold_req = 1'b0;
	bit          rx_always   = 1'b0;
	rx_pattern_t rx_mode     = RX_STEADY;

	logic [TIME_W-1:0] pkt_clock;

	probe_row_t probe_tab [N_PROBES] = '{
		// limiting off after reset: grant, average fixed at zero
		'{1'b0, 32'h0,        32'd5,        16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd0},
		'{1'b0, 32'h0,        32'hFFFFFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 32'd0},
		// widest limit, empty window
		'{1'b1, 32'hFFFFFFFF, 32'd0,        16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 32'd0},
		'{1'b0, 32'h0,        32'd0,        16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd0},
		'{1'b0, 32'h0,        32'd0,        16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		// time slightly ahead, then backwards
		'{1'b0, 32'h0,        32'd3,        16'd1234, 16'h0000, 1'b0, 1'b0, 32'd0},
		'{1'b0, 32'h0,        32'd2,        16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		// exactly one window ahead shifts everything out
		'{1'b0, 32'h0,        32'd11,       16'hFFFF, 16'h0000, 1'b0, 1'b0, 32'd0},
		// one past the window clears
		'{1'b0, 32'h0,        32'd20,       16'h0000, 16'hFFFF, 1'b1, 1'b1, 32'd0},
		'{1'b0, 32'h0,        32'd20,       16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		// tightest limit: deferral, window still advances
		'{1'b1, 32'd1,        32'd20,       16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		'{1'b0, 32'h0,        32'd21,       16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd0},
		// disabled again: state untouched
		'{1'b1, 32'd0,        32'd0,        16'h0000, 16'h0000, 1'b1, 1'b1, 32'd0},
		'{1'b1, 32'd1,        32'd21,       16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		// top of time clears the window
		'{1'b0, 32'h0,        32'hFFFFFFFF, 16'h0000, 16'h0000, 1'b1, 1'b1, 32'd0},
		'{1'b0, 32'h0,        32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 32'd0},
		'{1'b0, 32'h0,        32'hFFFFFFFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		// wrap back to zero is time running backwards, not far ahead
		'{1'b0, 32'h0,        32'd0,        16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		'{1'b0, 32'h0,        32'hFFFFFFF0, 16'h0000, 16'h0000, 1'b0, 1'b0, 32'd0},
		'{1'b1, 32'h80000000, 32'h55555555, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 32'd0},
		'{1'b0, 32'h0,        32'hAAAAAAAA, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 32'd0}
	};

	sliding_window_throughput_limiter #(
		.HEADER_BYTES  (HDR)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the shadow window to the packet's time, then decide and count it.
	function automatic void predict_decision(input logic [TIME_W-1:0] now,
			input logic [LEN_W-1:0] dlen, input logic [LEN_W-1:0] xlen,
			output logic granted, output logic [RATE_W-1:0] avg);
		logic [63:0]       sum;
		logic [63:0]       grown;
		logic [TIME_W-1:0] elapsed;
		int                s;
		int                i;
		if (lim_rate == '0) begin
			granted = 1'b1;
			avg     = '0;
			return;
		end
		if (now > win_base) begin
			if ({32'b0, now} > {32'b0, win_base} + 64'(WIN)) begin
				for (i = 0; i < WIN; i++)
					bucket_mem[i] = '0;
			end else begin
				elapsed = now - win_base;
				for (s = 0; s < int'(elapsed); s++) begin
					for (i = WIN - 1; i > 0; i--)
						bucket_mem[i] = bucket_mem[i - 1];
					bucket_mem[0] = '0;
				end
			end
			win_base = now;
		end
		sum = '0;
		for (i = 0; i < WIN; i++)
			sum += 64'(bucket_mem[i]);
		sum = sum / 64'(WIN);
		avg = sum[RATE_W-1:0];
		granted = (sum <= {32'b0, lim_rate});
		if (granted) begin
			grown = 64'(bucket_mem[0]) + 64'(dlen) + 64'(xlen) + 64'(HDR);
			bucket_mem[0] = (grown > 64'hFFFFFFFF) ? RATE_MAX : grown[RATE_W-1:0];
		end
	endfunction

	// Offer one packet and hold it until the transaction completes.
	task automatic offer_packet(input logic [TIME_W-1:0] now, input logic [LEN_W-1:0] dlen,
			input logic [LEN_W-1:0] xlen, input bit known = 1'b0,
			input bit k_granted = 1'b0, input logic [RATE_W-1:0] k_avg = '0);
		decision_t         want;
		logic              g;
		logic [RATE_W-1:0] a;
		s_tvalid <= 1'b1;
		s_tdata  <= {xlen, dlen, now};
		do @(posedge clk); while (!s_tready);
		predict_decision(now, dlen, xlen, g, a);
		want.granted = known ? k_granted : g;
		want.avg     = known ? k_avg : a;
		decision_q.push_back(want);
		packets_sent++;
	endtask

	task automatic pause_sender(input int gap);
		s_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Hold the input off until every outstanding decision has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (decision_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		lim_rate = v;
		rate_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly small steps forward, some backwards, some around the window edge, some jumps.
	function automatic logic [TIME_W-1:0] next_time(input logic [TIME_W-1:0] t);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return t + TIME_W'($urandom_range(0, 2));
		else if (pick < 80)
			return t - TIME_W'($urandom_range(1, 10));
		else if (pick < 90)
			return t + TIME_W'($urandom_range(WIN - 1, WIN + 1));
		else
			return TIME_W'($urandom);
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return '0;
		else if (pick < 30)
			return '1;
		else if (pick < 60)
			return LEN_W'($urandom_range(0, 1500));
		else
			return LEN_W'($urandom);
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate(input int phase);
		case (phase)
			0: return '0;
			1: return 32'd1;
			2: return RATE_MAX;
			default: begin
				case ($urandom_range(0, 4))
					0: return RATE_W'($urandom_range(100, 5000));
					1: return RATE_W'($urandom_range(5000, 60000));
					2: return RATE_W'($urandom_range(60000, 300000));
					3: return RATE_W'($urandom);
					default: return '0;
				endcase
			end
		endcase
	endfunction

	// Receiver: a changing stall pattern, a long hold-off on request, full speed when asked.
	initial begin : rx_side
		int hold_left;
		int mode_left;
		hold_left = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left   = 400;
				m_tready   <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_always) begin
				m_tready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_pattern_t'($urandom_range(0, 3));
					mode_left = $urandom_range(32, 400);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_STEADY:   m_tready <= 1'b1;
					RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
					default:     m_tready <= (cycle_cnt % 5 != 0);
				endcase
			end
		end
	end

	// Check every result transaction against the oldest expected decision.
	always @(posedge clk) begin
		decision_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decision_q.size() == 0) begin
				$error("unexpected result: granted %0d average_rate %0d",
					m_tdata[0], m_tdata[32:1]);
				mismatches++;
			end else begin
				want = decision_q.pop_front();
				decisions_seen++;
				if (!m_tdata[0])
					deferrals_seen++;
				if (m_tdata[0] !== want.granted) begin
					$error("granted mismatch: expected %0d, got %0d", want.granted, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[32:1] !== want.avg) begin
					$error("average_rate mismatch: expected %0d, got %0d",
						want.avg, m_tdata[32:1]);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: drop the run if it overstays the cycle budget.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("timeout after %0d cycles, %0d decisions outstanding",
				cycle_cnt, decision_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		int  r;
		int  p;
		int  n;
		int  burst_left;
		bit  gapless;
		for (r = 0; r < WIN; r++)
			bucket_mem[r] = '0;
		win_base   = '0;
		lim_rate   = '0;
		pkt_clock  = '0;
		burst_left = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: walk the probe table.
		for (r = 0; r < N_PROBES; r++) begin
			if (probe_tab[r].set_rate) begin
				drain_results();
				write_rate(probe_tab[r].rate);
			end
			offer_packet(probe_tab[r].now, probe_tab[r].dlen, probe_tab[r].xlen,
				probe_tab[r].known, probe_tab[r].granted, probe_tab[r].avg);
		end
		pkt_clock = probe_tab[N_PROBES - 1].now;

		// Random part: one limit setting per phase, bursty sender, gapless in some phases.
		for (p = 0; p < N_PHASES; p++) begin
			drain_results();
			write_rate(pick_rate(p));
			gapless = ($urandom_range(0, 3) == 0);
			for (n = 0; n < PHASE_PKTS; n++) begin
				// Starve the output for a long stretch while packets keep coming.
				if (p == 3 && n == 40)
					rx_hold_req = 1'b1;
				// Stop offering until every decision is back, then carry on.
				if (p == 5 && n == 75)
					drain_results();
				if (!gapless) begin
					if (burst_left == 0) begin
						pause_sender($urandom_range(1, 8));
						burst_left = $urandom_range(1, 24);
					end else begin
						burst_left--;
					end
				end
				pkt_clock = next_time(pkt_clock);
				offer_packet(pkt_clock, pick_len(), pick_len());
			end
		end

		// Pile maximum-size packets into the newest bucket, back to back.
		drain_results();
		write_rate(RATE_MAX);
		rx_always = 1'b1;
		for (n = 0; n < PILE_PKTS; n++)
			offer_packet(pkt_clock, '1, '1);
		drain_results();
		rx_always = 1'b0;

		repeat (60) @(posedge clk);
		$display("Covered %0d packets (%0d directed) under %0d limit settings.",
			packets_sent, N_PROBES, rate_writes);
		$display("Checked %0d decisions, %0d of them deferrals; %0d mismatches.",
			decisions_seen, deferrals_seen, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
